FILE: design/npn_pkg.sv
// npn_pkg: shared types and fixed widths for the Newell polygon normal block.
// Depends on nothing; every other file of the block but npn_queue imports it.
package npn_pkg;

    localparam int COORD_W     = 16;
    localparam int NORM_W      = 16;
    localparam int MIN_VERTICES = 3;
    localparam int QUEUE_DEPTH = 2;

    // back end widths
    localparam int NORM_MSB = 29;            // normalized magnitude lies in [2^29, 2^30)
    localparam int MAG_W    = NORM_MSB + 1;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int L2_W     = SQ_W + 2;
    localparam int ROOT_W   = L2_W + 1;
    localparam int R_W      = MAG_W + 1;
    localparam int D_W      = R_W + 1;
    localparam int Q_W      = 15;
    localparam int QCNT_W   = $clog2(Q_W);

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last_vertex;
    } t_vertex_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vertex;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic                     degenerate;
    } t_result;

    // one edge operation travelling down the front pipeline
    typedef struct packed {
        logic valid;
        logic en;      // edge adds to the sums
        logic final_op; // polygon closes after this edge
        logic ok;      // vertex count in range
    } t_edge_op;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_NORM = 8'b0000_0010,
        S_SQR  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_ROOT = 8'b0001_0000,
        S_PREP = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_back_state;

endpackage

FILE: design/npn_queue.sv
// npn_queue: small register FIFO carrying closed-polygon sums from front to back.
// Depends on no other file; width and depth are parameters.
module npn_queue #(
    parameter int W     = 133,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_push_data,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

endmodule

FILE: design/npn_front.sv
// npn_front: vertex intake, edge issue and Newell accumulation pipeline.
// Depends on npn_pkg; pushes closed-polygon sums into npn_queue.
module npn_front #(
    parameter int MAX_VERTICES = 256,
    parameter int SUM_W        = 44
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  npn_pkg::t_vertex_in i_in_data,
    output logic                o_push,
    output logic [3*SUM_W:0]    o_push_data,
    input  logic                i_pop
);
    import npn_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);
    localparam int CRD_W = $clog2(QUEUE_DEPTH + 1);
    localparam int P_W   = 2 * (COORD_W + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_close, n_close;
    logic             r_close_ok, n_close_ok;
    logic [CRD_W-1:0] r_credit, n_credit;
    t_edge_op         r_e, n_e;
    t_edge_op         r_p;
    t_vertex          r_first, r_prev, r_eu, r_ev, n_ev;
    logic signed [P_W-1:0]   r_px, r_py, r_pz;
    logic signed [P_W-1:0]   px, py, pz;
    logic signed [SUM_W-1:0] r_sx, r_sy, r_sz;
    logic signed [SUM_W-1:0] add_x, add_y, add_z;
    logic signed [COORD_W:0] dx, dy, dz, ax, ay, az;

    logic             accept, issue_final, edge_issue, first_we, prev_we;
    logic [CNT_W-1:0] cnt_up;
    t_vertex          v;

    assign accept      = i_in_valid && !r_close;
    assign issue_final = r_close && (r_credit < CRD_W'(QUEUE_DEPTH));
    assign v           = '{x: i_in_data.x, y: i_in_data.y, z: i_in_data.z};

    always_comb begin
        n_count    = r_count;
        n_close    = r_close;
        n_close_ok = r_close_ok;
        edge_issue = 1'b0;
        first_we   = 1'b0;
        prev_we    = 1'b0;
        cnt_up     = r_count;
        if (accept) begin
            if (r_count >= CNT_W'(MAX_VERTICES)) begin
                cnt_up = CNT_W'(MAX_VERTICES + 1);
            end else begin
                if (r_count == '0) begin
                    first_we = 1'b1;
                end else begin
                    edge_issue = 1'b1;
                end
                prev_we = 1'b1;
                cnt_up  = r_count + 1'b1;
            end
            if (i_in_data.last_vertex) begin
                n_close    = 1'b1;
                n_close_ok = (cnt_up >= CNT_W'(MIN_VERTICES))
                          && (cnt_up <= CNT_W'(MAX_VERTICES));
                n_count    = '0;
            end else begin
                n_count = cnt_up;
            end
        end
        if (issue_final) begin
            n_close = 1'b0;
        end
        n_e.valid    = edge_issue || issue_final;
        n_e.en       = edge_issue || (issue_final && r_close_ok);
        n_e.final_op = issue_final;
        n_e.ok       = r_close_ok;
        n_ev         = issue_final ? r_first : v;
        n_credit     = r_credit + CRD_W'(issue_final) - CRD_W'(i_pop);
    end

    // Newell cross terms, u = previous vertex, v = current vertex
    always_comb begin
        dx = (COORD_W+1)'(r_eu.x) - (COORD_W+1)'(r_ev.x);
        dy = (COORD_W+1)'(r_eu.y) - (COORD_W+1)'(r_ev.y);
        dz = (COORD_W+1)'(r_eu.z) - (COORD_W+1)'(r_ev.z);
        ax = (COORD_W+1)'(r_eu.x) + (COORD_W+1)'(r_ev.x);
        ay = (COORD_W+1)'(r_eu.y) + (COORD_W+1)'(r_ev.y);
        az = (COORD_W+1)'(r_eu.z) + (COORD_W+1)'(r_ev.z);
        px = dy * az;
        py = dz * ax;
        pz = dx * ay;
    end

    always_comb begin
        add_x = r_sx + (r_p.en ? SUM_W'(r_px) : '0);
        add_y = r_sy + (r_p.en ? SUM_W'(r_py) : '0);
        add_z = r_sz + (r_p.en ? SUM_W'(r_pz) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_close    <= 1'b0;
            r_close_ok <= 1'b0;
            r_credit   <= '0;
            r_e        <= '0;
            r_p        <= '0;
            r_sx       <= '0;
            r_sy       <= '0;
            r_sz       <= '0;
        end else begin
            r_count    <= n_count;
            r_close    <= n_close;
            r_close_ok <= n_close_ok;
            r_credit   <= n_credit;
            r_e        <= n_e;
            r_p        <= r_e;
            if (r_p.valid) begin
                if (r_p.final_op) begin
                    r_sx <= '0;
                    r_sy <= '0;
                    r_sz <= '0;
                end else begin
                    r_sx <= add_x;
                    r_sy <= add_y;
                    r_sz <= add_z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (first_we) begin
            r_first <= v;
        end
        if (prev_we) begin
            r_prev <= v;
        end
        r_eu <= r_prev;
        r_ev <= n_ev;
        r_px <= px;
        r_py <= py;
        r_pz <= pz;
    end

    assign o_in_stall  = r_close;
    assign o_push      = r_p.valid && r_p.final_op;
    assign o_push_data = {r_p.ok, add_x, add_y, add_z};

endmodule

FILE: design/npn_back.sv
// npn_back: sequential normalization of Newell sums into a Q1.14 unit normal.
// Depends on npn_pkg; pops sums from npn_queue and drives the result register.
module npn_back #(
    parameter int SUM_W = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  logic [3*SUM_W:0] i_q_data,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output npn_pkg::t_result o_out_data
);
    import npn_pkg::*;

    t_back_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_result     r_out;
    logic        r_degen;

    logic [SUM_W-1:0]  r_mag [3];
    logic              r_neg [3];
    logic [SQ_W-1:0]   r_sq  [3];
    logic [L2_W-1:0]   r_n;
    logic [ROOT_W-1:0] r_res, r_bit;
    logic [D_W-1:0]    r_div;
    logic [D_W-1:0]    r_rem [3];
    logic [Q_W-1:0]    r_quo [3];
    logic [Q_W-1:0]    r_low;
    logic [QCNT_W-1:0] r_cnt;

    logic [SUM_W-1:0]  s   [3];
    logic [SUM_W-1:0]  mag [3];
    logic [SUM_W-1:0]  orv;
    logic              all_zero, load_out;
    logic [ROOT_W-1:0] trial;
    logic              take;
    logic [D_W:0]      t   [3];
    logic              ge  [3];

    assign s[0] = i_q_data[3*SUM_W-1:2*SUM_W];
    assign s[1] = i_q_data[2*SUM_W-1:SUM_W];
    assign s[2] = i_q_data[SUM_W-1:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = s[i][SUM_W-1] ? (~s[i] + 1'b1) : s[i];
            t[i]   = {r_rem[i], r_low[Q_W-1]};
            ge[i]  = (t[i] >= {1'b0, r_div});
        end
        all_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
        orv      = r_mag[0] | r_mag[1] | r_mag[2];
        trial    = r_res + r_bit;
        take     = ({1'b0, r_n} >= trial);
    end

    assign o_q_pop  = r_state[0] && i_q_valid;
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = (!i_q_data[3*SUM_W] || all_zero) ? S_DONE : S_NORM;
                end
            end
            S_NORM: begin
                if (orv[NORM_MSB] && (orv[SUM_W-1:NORM_MSB+1] == '0)) begin
                    n_state = S_SQR;
                end
            end
            S_SQR:  n_state = S_ADD;
            S_ADD:  n_state = S_ROOT;
            S_ROOT: begin
                if (r_bit[0]) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = load_out ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    r_mag[i] <= mag[i];
                    r_neg[i] <= s[i][SUM_W-1];
                end
                r_degen <= !i_q_data[3*SUM_W] || all_zero;
            end
            S_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (orv[SUM_W-1:NORM_MSB+4] != '0) begin
                        r_mag[i] <= r_mag[i] >> 4;
                    end else if (orv[NORM_MSB+3:NORM_MSB+1] != '0) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end else if (orv[NORM_MSB]) begin
                        r_mag[i] <= r_mag[i];
                    end else if (orv[NORM_MSB:NORM_MSB-4] == '0) begin
                        r_mag[i] <= r_mag[i] << 4;
                    end else begin
                        r_mag[i] <= r_mag[i] << 1;
                    end
                end
            end
            S_SQR: begin
                for (int i = 0; i < 3; i++) begin
                    r_sq[i] <= r_mag[i][MAG_W-1:0] * r_mag[i][MAG_W-1:0];
                end
            end
            S_ADD: begin
                r_n   <= L2_W'(r_sq[0]) + L2_W'(r_sq[1]) + L2_W'(r_sq[2]);
                r_res <= '0;
                r_bit <= ROOT_W'(1) << (ROOT_W - 1);
            end
            S_ROOT: begin
                if (take) begin
                    r_n   <= r_n - trial[L2_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_PREP: begin
                r_div <= {r_res[R_W-1:0], 1'b0};
                r_low <= r_res[Q_W-1:0];
                r_cnt <= QCNT_W'(Q_W - 1);
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= D_W'(r_mag[i][MAG_W-1:0]) + D_W'(r_res[R_W-1:Q_W]);
                    r_quo[i] <= '0;
                end
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= ge[i] ? D_W'(t[i] - {1'b0, r_div}) : t[i][D_W-1:0];
                    r_quo[i] <= {r_quo[i][Q_W-2:0], ge[i]};
                end
                r_low <= r_low << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            if (r_degen) begin
                r_out <= '{normal_x: '0, normal_y: '0, normal_z: '0, degenerate: 1'b1};
            end else begin
                r_out.normal_x   <= r_neg[0] ? -NORM_W'(r_quo[0]) : NORM_W'(r_quo[0]);
                r_out.normal_y   <= r_neg[1] ? -NORM_W'(r_quo[1]) : NORM_W'(r_quo[1]);
                r_out.normal_z   <= r_neg[2] ? -NORM_W'(r_quo[2]) : NORM_W'(r_quo[2]);
                r_out.degenerate <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/newell_polygon_normal.sv
// newell_polygon_normal: top level, front accumulator, sum queue and normalizer.
// Depends on npn_pkg, npn_front, npn_queue and npn_back.
//
// Vertices of a polygon enter in Q8.8, one request per cycle while o_in_stall
// is low; after the vertex with last_vertex set, the input stalls while the
// closing edge is issued. Up to two closed polygons wait in the queue between
// the accumulator and the normalizer; while both slots are taken, the closing
// edge waits and the input stalls. The normalizer works on one polygon at a
// time: a regular normal takes a shift search, a 32-step square root and a
// 15-step division over three lanes, a degenerate one none of them, so
// polygons of fewer than about 55 vertices are paced by the normalizer.
// Results come out in Q1.14 in polygon order.
module newell_polygon_normal #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  npn_pkg::t_vertex_in i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output npn_pkg::t_result    o_out_data
);
    import npn_pkg::*;

    localparam int SUM_W = $clog2(MAX_VERTICES) + 36;
    localparam int QW    = 3 * SUM_W + 1;

    logic          push, pop, q_valid;
    logic [QW-1:0] push_data, q_data;

    npn_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_pop       (pop)
    );

    npn_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    npn_back #(
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_data),
        .o_q_pop     (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: sim/newell_polygon_normal_test.sv
// newell_polygon_normal_test: self-checking bench for the Newell polygon normal block.
// Streams vertex requests with random gaps and output stalls, predicts each unit normal
// in fixed point and compares it field by field. Depends on npn_pkg and newell_polygon_normal.
module newell_polygon_normal_test;
    import npn_pkg::*;

    localparam int MAX_VERTS    = 256;
    localparam int RANDOM_ITEMS = 470;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic { BY_MODEL, BY_TABLE } t_check_src;
    typedef enum int { COORD_FULL, COORD_SMALL, COORD_EXTREME, COORD_PLANAR } t_coord_style;

    typedef struct packed {
        t_vertex_in  vtx;
        logic [15:0] reps;
        t_check_src  src;
        t_result     want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_vertex_in i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_result    o_out_data;

    // polygon state of the predictor
    t_vertex first_vtx;
    t_vertex prev_vtx;
    longint  sum_x;
    longint  sum_y;
    longint  sum_z;
    int      vtx_count;

    t_result   expected_normals[$];
    t_stim_row directed_rows[$];
    int        mismatches    = 0;
    int        results_taken = 0;
    int        items_sent    = 0;
    int        idle_cycles   = 0;
    bit        quiet         = 1'b0;

    newell_polygon_normal #(
        .MAX_VERTICES(MAX_VERTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_polygon();
        first_vtx = '0;
        prev_vtx  = '0;
        sum_x     = 0;
        sum_y     = 0;
        sum_z     = 0;
        vtx_count = 0;
    endfunction

    function automatic void queue_normal(input t_result n);
        expected_normals.insert(expected_normals.size(), n);
    endfunction

    function automatic void add_row(input t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void accumulate_edge(input t_vertex u, input t_vertex v);
        longint ux, uy, uz, vx, vy, vz;
        ux = longint'(u.x);
        uy = longint'(u.y);
        uz = longint'(u.z);
        vx = longint'(v.x);
        vy = longint'(v.y);
        vz = longint'(v.z);
        sum_x += (uy - vy) * (uz + vz);
        sum_y += (uz - vz) * (ux + vx);
        sum_z += (ux - vx) * (uy + vy);
    endfunction

    function automatic longint unsigned isqrt(input longint unsigned n);
        longint unsigned root, bits;
        root = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0) begin
            if (n >= root + bits) begin
                n -= root + bits;
                root = (root >> 1) + bits;
            end else begin
                root >>= 1;
            end
            bits >>= 2;
        end
        return root;
    endfunction

    // returns 1 when the vertex closes a polygon; res then holds its normal
    function automatic bit predict_normal(input t_vertex_in vin, output t_result res);
        t_vertex            v;
        longint             s[3];
        longint unsigned    mag[3];
        longint unsigned    m, l2, r, q;
        int                 top;
        logic signed [15:0] comp[3];
        v   = '{vin.x, vin.y, vin.z};
        res = '0;
        if (vtx_count >= MAX_VERTS) begin
            vtx_count = MAX_VERTS + 1;
        end else begin
            if (vtx_count == 0) first_vtx = v;
            else accumulate_edge(prev_vtx, v);
            prev_vtx = v;
            vtx_count++;
        end
        if (!vin.last_vertex) return 1'b0;
        res.degenerate = 1'b1;
        if (vtx_count >= MIN_VERTICES && vtx_count <= MAX_VERTS) begin
            accumulate_edge(prev_vtx, first_vtx);
            s[0] = sum_x;
            s[1] = sum_y;
            s[2] = sum_z;
            m = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = s[i] < 0 ? -s[i] : s[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m != 0) begin
                top = 63;
                while (!m[top]) top--;
                for (int i = 0; i < 3; i++) begin
                    if (top < NORM_MSB) mag[i] = mag[i] << (NORM_MSB - top);
                    else mag[i] = mag[i] >> (top - NORM_MSB);
                end
                l2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
                r  = isqrt(l2);
                for (int i = 0; i < 3; i++) begin
                    q       = (mag[i] * 64'd32768 + r) / (64'd2 * r);
                    comp[i] = 16'(s[i] < 0 ? -q : q);
                end
                res = '{comp[0], comp[1], comp[2], 1'b0};
            end
        end
        clear_polygon();
        return 1'b1;
    endfunction

    function automatic t_stim_row stim_row(input int x, y, z, input bit last, input int reps,
                                           input t_check_src src, input int nx, ny, nz,
                                           input bit deg);
        t_stim_row row;
        row.vtx  = '{16'(x), 16'(y), 16'(z), last};
        row.reps = 16'(reps);
        row.src  = src;
        row.want = '{16'(nx), 16'(ny), 16'(nz), deg};
        return row;
    endfunction

    function automatic logic signed [15:0] random_coord(input t_coord_style style);
        case (style)
            COORD_SMALL: return 16'($urandom_range(0, 1023) - 512);
            COORD_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'hFFFF;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_vertex_in random_vertex(input t_coord_style style,
                                                 input logic signed [15:0] plane_z);
        t_vertex_in v;
        if (style == COORD_PLANAR) begin
            v.x = random_coord(COORD_SMALL);
            v.y = random_coord(COORD_SMALL);
            v.z = plane_z;
        end else begin
            v.x = random_coord(style);
            v.y = random_coord(style);
            v.z = random_coord(style);
        end
        v.last_vertex = 1'b0;
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_vertex(input t_vertex_in v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = v;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic wait_for_normals();
        i_in_valid = 1'b0;
        while (expected_normals.size() != 0) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        if (mismatches < MAX_REPORTS)
            $display("%s: expected (%0d %0d %0d deg %0b) got (%0d %0d %0d deg %0b)", what,
                     want.normal_x, want.normal_y, want.normal_z, want.degenerate,
                     got.normal_x, got.normal_y, got.normal_z, got.degenerate);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : take_normal
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_taken++;
            if (expected_normals.size() == 0) begin
                report_mismatch("normal with none pending", '0, o_out_data);
            end else begin
                want = expected_normals.pop_front();
                if (want.normal_x !== o_out_data.normal_x ||
                    want.normal_y !== o_out_data.normal_y ||
                    want.normal_z !== o_out_data.normal_z ||
                    want.degenerate !== o_out_data.degenerate)
                    report_mismatch("normal mismatch", want, o_out_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : out_side
        int hold, seen;
        i_out_stall = 1'b0;
        hold        = $urandom_range(0, 16);
        seen        = 0;
        forever begin
            @(negedge i_clk);
            if (results_taken != seen) begin
                seen = results_taken;
                hold = quiet ? 0 : $urandom_range(0, 16);
            end
            i_out_stall = hold > 0;
            if (hold > 0) hold--;
        end
    end

    initial begin : in_side
        t_vertex_in         vtx;
        t_result            normal;
        t_coord_style       style;
        logic signed [15:0] plane_z;
        int                 n_verts, pick, long_polys, start;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        clear_polygon();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single vertex, two vertices
        add_row(stim_row(0, 0, 0, 1, 1, BY_TABLE, 0, 0, 0, 1));
        add_row(stim_row(256, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 1, 1, BY_TABLE, 0, 0, 0, 1));
        // square in the xy plane, counterclockwise
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 256, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 1, 1, BY_TABLE, 0, 0, 16384, 0));
        // clockwise triangle
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 0, 0, 1, 1, BY_TABLE, 0, 0, -16384, 0));
        // triangle in the yz plane
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 0, 256, 1, 1, BY_TABLE, 16384, 0, 0, 0));
        // collinear: zero-length normal
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 256, 256, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(512, 512, 512, 1, 1, BY_TABLE, 0, 0, 0, 1));
        // coordinate extremes
        add_row(stim_row(-32768, -32768, -32768, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(32767, -32768, 32767, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(32767, 32767, -32768, 1, 1, BY_MODEL, 0, 0, 0, 0));
        // exactly the vertex limit
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 0, 0, 0, 254, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 1, 1, BY_TABLE, 0, 0, 16384, 0));
        // one vertex over the limit
        add_row(stim_row(0, 0, 0, 0, 1, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(256, 0, 0, 0, 255, BY_MODEL, 0, 0, 0, 0));
        add_row(stim_row(0, 256, 0, 1, 1, BY_TABLE, 0, 0, 0, 1));

        foreach (directed_rows[k]) begin
            repeat (directed_rows[k].reps) begin
                vtx = directed_rows[k].vtx;
                if (predict_normal(vtx, normal))
                    queue_normal(directed_rows[k].src == BY_TABLE ?
                                 directed_rows[k].want : normal);
                send_vertex(vtx);
            end
        end
        wait_for_normals();

        long_polys = 0;
        start      = items_sent;
        while (items_sent < start + RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) quiet = !quiet;
            if ($urandom_range(0, 19) == 0) wait_for_normals();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                n_verts = $urandom_range(1, 2);
            end else if (pick < 10 && long_polys < 3) begin
                n_verts = $urandom_range(250, 270);
                long_polys++;
            end else begin
                n_verts = $urandom_range(3, 12);
            end
            style   = t_coord_style'($urandom_range(0, 3));
            plane_z = random_coord(COORD_FULL);
            for (int j = 0; j < n_verts; j++) begin
                vtx             = random_vertex(style, plane_z);
                vtx.last_vertex = (j == n_verts - 1);
                if (predict_normal(vtx, normal)) queue_normal(normal);
                send_vertex(vtx);
            end
        end

        wait_for_normals();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/npn_pkg.sv
design/npn_queue.sv
design/npn_front.sv
design/npn_back.sv
design/newell_polygon_normal.sv
sim/newell_polygon_normal_test.sv
